@@ src/cpio_pkg.sv @@
`timescale 1ns / 1ps

package cpio_pkg;

  // Geometry of a newc header.
  localparam int HDR_LEN           = 110;
  localparam int HDR_IDX_W         = 7;
  localparam int MAGIC_LEN         = 6;
  localparam int FSIZE_FIRST       = 54;
  localparam int FSIZE_LAST        = 61;
  localparam int NSIZE_FIRST       = 94;
  localparam int NSIZE_LAST        = 101;

  localparam logic [7:0] MAGIC_TEXT [MAGIC_LEN] = '{
    8'h30, 8'h37, 8'h30, 8'h37, 8'h30, 8'h31
  };

  localparam int TRAILER_LEN = 10;
  localparam logic [7:0] TRAILER_TEXT [TRAILER_LEN] = '{
    8'h54, 8'h52, 8'h41, 8'h49, 8'h4C, 8'h45, 8'h52, 8'h21, 8'h21, 8'h21
  };

  // Target name storage.
  localparam int TARGET_NAME_BYTES = 16;
  localparam int TGT_IDX_W         = $clog2(TARGET_NAME_BYTES);
  localparam int CFG_DATA_W        = 64;
  localparam int TARGET_BITS       = 2 * CFG_DATA_W;
  localparam int TLEN_W            = 5;

  // The name position counter saturates one past the longest name that can
  // still match the target or the trailer string.
  localparam int NAME_POS_SAT = (TARGET_NAME_BYTES > TRAILER_LEN ?
                                 TARGET_NAME_BYTES : TRAILER_LEN) + 1;
  localparam int NAME_POS_W   = $clog2(NAME_POS_SAT + 1);

  localparam int SIZE_W  = 32;
  localparam int VALUE_W = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIND_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEN  = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_NAME     = 3'd1,
    PH_NAME_PAD = 3'd2,
    PH_DATA     = 3'd3,
    PH_DATA_PAD = 3'd4,
    PH_HALT     = 3'd5
  } cpio_phase_t;

  typedef enum logic [2:0] {
    KIND_NAME_BYTE = 3'd0,
    KIND_ENTRY     = 3'd1,
    KIND_FOUND     = 3'd2,
    KIND_DATA_BYTE = 3'd3,
    KIND_BAD_MAGIC = 3'd4,
    KIND_END       = 3'd5
  } cpio_kind_t;

  typedef struct packed {
    cpio_phase_t             phase;
    logic [HDR_IDX_W-1:0]    hdr_idx;
    logic                    magic_good;
    logic [SIZE_W-1:0]       name_size;
    logic [SIZE_W-1:0]       file_size;
    logic [SIZE_W-1:0]       bytes_left;
    logic [1:0]              pos_mod4;
    logic [NAME_POS_W-1:0]   name_pos;
    logic                    name_open;
    logic                    target_match;
    logic                    trailer_match;
  } cpio_state_t;

  typedef struct packed {
    logic                    find_mode;
    logic [TARGET_BITS-1:0]  target;
    logic [TLEN_W-1:0]       target_len;
  } cpio_cfg_t;

  typedef struct packed {
    logic                    valid;
    cpio_kind_t              kind;
    logic [VALUE_W-1:0]      value;
    logic                    is_trailer;
    logic                    last;
  } cpio_result_t;

endpackage

@@ src/cpio_step.sv @@
`timescale 1ns / 1ps

// Next-state and result logic for one archive byte.
module cpio_step import cpio_pkg::*; (
  input  cpio_state_t  st,
  input  cpio_cfg_t    cfg,
  input  logic [7:0]   byte_in,
  input  logic         restart,
  output cpio_state_t  st_nxt,
  output cpio_result_t res
);

  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX  = HDR_IDX_W'(HDR_LEN - 1);
  localparam logic [HDR_IDX_W-1:0] MAGIC_END_IDX = HDR_IDX_W'(MAGIC_LEN);
  localparam logic [HDR_IDX_W-1:0] MAGIC_LAST    = HDR_IDX_W'(MAGIC_LEN - 1);
  localparam logic [HDR_IDX_W-1:0] FS_FIRST      = HDR_IDX_W'(FSIZE_FIRST);
  localparam logic [HDR_IDX_W-1:0] FS_LAST       = HDR_IDX_W'(FSIZE_LAST);
  localparam logic [HDR_IDX_W-1:0] NS_FIRST      = HDR_IDX_W'(NSIZE_FIRST);
  localparam logic [HDR_IDX_W-1:0] NS_LAST       = HDR_IDX_W'(NSIZE_LAST);
  localparam logic [NAME_POS_W-1:0] POS_SAT      = NAME_POS_W'(NAME_POS_SAT);
  localparam logic [NAME_POS_W-1:0] TRAILER_POS  = NAME_POS_W'(TRAILER_LEN);
  localparam logic [NAME_POS_W-1:0] TARGET_MAX   = NAME_POS_W'(TARGET_NAME_BYTES);

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end
    return d[3:0];
  endfunction

  function automatic cpio_state_t go_header(input cpio_state_t x);
    cpio_state_t y;
    y            = x;
    y.phase      = PH_HEADER;
    y.hdr_idx    = '0;
    y.magic_good = 1'b1;
    y.name_size  = '0;
    y.file_size  = '0;
    return y;
  endfunction

  function automatic cpio_state_t after_data(input cpio_state_t x);
    cpio_state_t y;
    y = x;
    if (x.pos_mod4 != 2'd0) begin
      y.phase = PH_DATA_PAD;
    end else begin
      y = go_header(x);
    end
    return y;
  endfunction

  function automatic cpio_state_t start_data(input cpio_state_t x);
    cpio_state_t y;
    y = x;
    if (x.file_size == '0) begin
      if (x.target_match) begin
        y.phase = PH_HALT;
      end else begin
        y = after_data(x);
      end
    end else begin
      y.bytes_left = x.file_size;
      y.phase      = PH_DATA;
    end
    return y;
  endfunction

  function automatic cpio_state_t after_name(input cpio_state_t x);
    cpio_state_t y;
    y = x;
    if (x.pos_mod4 != 2'd0) begin
      y.phase = PH_NAME_PAD;
    end else begin
      y = start_data(x);
    end
    return y;
  endfunction

  cpio_state_t           s;
  cpio_state_t           n;
  logic [NAME_POS_W-1:0] tlen;
  logic                  magic_ok;
  logic                  is_char;
  logic                  eon;
  logic                  trailer;
  logic                  match;
  logic                  out_now;
  logic [7:0]            tgt_byte;
  logic [7:0]            trl_byte;

  always_comb begin
    if (cfg.target_len > TLEN_W'(TARGET_NAME_BYTES)) begin
      tlen = TARGET_MAX;
    end else begin
      tlen = NAME_POS_W'(cfg.target_len);
    end
  end

  always_comb begin
    s = st;
    if (restart) begin
      s               = go_header(st);
      s.bytes_left    = '0;
      s.pos_mod4      = 2'd0;
      s.name_pos      = '0;
      s.target_match  = 1'b1;
      s.trailer_match = 1'b1;
    end

    n              = s;
    res.valid      = 1'b0;
    res.kind       = KIND_NAME_BYTE;
    res.value      = '0;
    res.is_trailer = 1'b0;
    res.last       = 1'b0;
    magic_ok       = s.magic_good;
    is_char        = 1'b0;
    eon            = 1'b0;
    trailer        = 1'b0;
    match          = 1'b0;
    out_now        = s.target_match;
    tgt_byte       = cfg.target[{s.name_pos[TGT_IDX_W-1:0], 3'b000} +: 8];
    trl_byte       = TRAILER_TEXT[s.name_pos[3:0]];

    if (s.phase != PH_HALT) begin
      n.pos_mod4 = s.pos_mod4 + 2'd1;
      unique case (s.phase)
        PH_HEADER: begin
          if (s.hdr_idx < MAGIC_END_IDX && byte_in != MAGIC_TEXT[s.hdr_idx[2:0]]) begin
            magic_ok = 1'b0;
          end
          n.magic_good = magic_ok;
          if (s.hdr_idx == MAGIC_LAST && !magic_ok) begin
            n.phase   = PH_HALT;
            res.valid = 1'b1;
            res.kind  = KIND_BAD_MAGIC;
          end else begin
            if (s.hdr_idx >= FS_FIRST && s.hdr_idx <= FS_LAST) begin
              n.file_size = {s.file_size[SIZE_W-5:0], hex_digit(byte_in)};
            end
            if (s.hdr_idx >= NS_FIRST && s.hdr_idx <= NS_LAST) begin
              n.name_size = {s.name_size[SIZE_W-5:0], hex_digit(byte_in)};
            end
            if (s.hdr_idx != HDR_LAST_IDX) begin
              n.hdr_idx = s.hdr_idx + 1'b1;
            end else begin
              n.hdr_idx       = '0;
              n.name_pos      = '0;
              n.name_open     = 1'b1;
              n.target_match  = 1'b1;
              n.trailer_match = 1'b1;
              n.bytes_left    = n.name_size;
              n.phase         = PH_NAME;
              eon             = (n.name_size == '0);
            end
          end
        end
        PH_NAME: begin
          if (s.name_open && byte_in != 8'h00) begin
            if (!(s.name_pos < TRAILER_POS && byte_in == trl_byte)) begin
              n.trailer_match = 1'b0;
            end
            if (!(s.name_pos < tlen && byte_in == tgt_byte)) begin
              n.target_match = 1'b0;
            end
            if (s.name_pos != POS_SAT) begin
              n.name_pos = s.name_pos + 1'b1;
            end
            is_char = 1'b1;
          end else if (byte_in == 8'h00) begin
            n.name_open = 1'b0;
          end
          n.bytes_left = s.bytes_left - 1'b1;
          if (n.bytes_left == '0) begin
            eon = 1'b1;
          end else if (is_char && !cfg.find_mode) begin
            res.valid = 1'b1;
            res.kind  = KIND_NAME_BYTE;
            res.value = VALUE_W'(byte_in);
          end
        end
        PH_NAME_PAD: begin
          if (n.pos_mod4 == 2'd0) begin
            n = start_data(n);
          end
        end
        PH_DATA: begin
          n.bytes_left = s.bytes_left - 1'b1;
          if (n.bytes_left == '0) begin
            if (out_now) begin
              n.phase = PH_HALT;
            end else begin
              n = after_data(n);
            end
          end
          if (out_now) begin
            res.valid = 1'b1;
            res.kind  = KIND_DATA_BYTE;
            res.value = VALUE_W'(byte_in);
            res.last  = (n.bytes_left == '0);
          end
        end
        PH_DATA_PAD: begin
          if (n.pos_mod4 == 2'd0) begin
            n = go_header(n);
          end
        end
        PH_HALT: begin
          n = s;
        end
        default: begin
          n = s;
        end
      endcase
    end

    // End of the name field: emit the record, if any, and pick the next phase.
    if (eon) begin
      trailer = n.trailer_match && n.name_pos == TRAILER_POS;
      match   = n.target_match && n.name_pos == tlen;
      if (!cfg.find_mode) begin
        res.valid      = 1'b1;
        res.kind       = KIND_ENTRY;
        res.value      = n.file_size;
        res.is_trailer = trailer;
        res.last       = 1'b0;
        if (trailer) begin
          n.phase = PH_HALT;
        end else begin
          n.target_match = 1'b0;
          n = after_name(n);
        end
      end else if (trailer) begin
        n.phase   = PH_HALT;
        res.valid = 1'b1;
        res.kind  = KIND_END;
        res.value = '0;
        res.last  = 1'b0;
      end else begin
        n.target_match = match;
        n = after_name(n);
        res.valid = match;
        res.kind  = KIND_FOUND;
        res.value = n.file_size;
        res.last  = 1'b0;
      end
    end

    st_nxt = n;
  end

endmodule

@@ src/cpio_newc_stream_parser.sv @@
`timescale 1ns / 1ps

// Streaming parser for cpio newc archives. The archive enters one byte per
// beat on the in_ channel, with in_tuser set on the first byte of a new
// archive. The block checks the magic of every 110-byte header, decodes the
// name size and file size, walks the name and data with their padding to
// four bytes, and stops at the TRAILER!!! entry. With find mode clear it
// sends every name character and then an entry record carrying the file
// size; with find mode set it compares each name with the configured target
// and sends a found record followed by the file's data bytes, the final one
// marked by out_tlast. A bad magic, the end of the archive or the end of the
// found file stops the parse until the next restart byte. The parse state
// is updated at the beat that takes a byte and at most one result beat goes
// into a single output register, so a new byte is taken every cycle as long
// as the result side keeps up. Configuration is written on the cfg_ port,
// which is always ready, and must only change while the stream is idle.
module cpio_newc_stream_parser import cpio_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // archive_byte
  input  logic                  in_tuser,   // restart

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [VALUE_W-1:0]    out_tdata,  // value
  output logic [3:0]            out_tuser,  // kind [2:0], is_trailer [3]
  output logic                  out_tlast,  // last_data

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cpio_state_t           st_r;
  cpio_state_t           st_nxt;
  cpio_cfg_t             cfg_r;
  cpio_result_t          res;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [VALUE_W-1:0]    out_value_r;
  cpio_kind_t            out_kind_r;
  logic                  out_trailer_r;
  logic                  out_last_r;
  logic                  in_accept;

  // The output register is free when empty or being drained this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  cpio_step u_step (
    .st      (st_r),
    .cfg     (cfg_r),
    .byte_in (in_tdata),
    .restart (in_tuser),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.find_mode  <= 1'b0;
      cfg_r.target     <= '0;
      cfg_r.target_len <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIND_MODE:   cfg_r.find_mode <= cfg_data[0];
        CFG_TARGET_LOW:  cfg_r.target[CFG_DATA_W-1:0] <= cfg_data;
        CFG_TARGET_HIGH: cfg_r.target[TARGET_BITS-1:CFG_DATA_W] <= cfg_data;
        CFG_TARGET_LEN:  cfg_r.target_len <= cfg_data[TLEN_W-1:0];
        default:         cfg_r.find_mode <= cfg_r.find_mode;
      endcase
    end
  end

  // Parse state, held as it stands after reset: the values a restart byte
  // would load, with name_open set as well, which a restart leaves alone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase         <= PH_HEADER;
      st_r.hdr_idx       <= '0;
      st_r.magic_good    <= 1'b1;
      st_r.name_size     <= '0;
      st_r.file_size     <= '0;
      st_r.bytes_left    <= '0;
      st_r.pos_mod4      <= 2'd0;
      st_r.name_pos      <= '0;
      st_r.name_open     <= 1'b1;
      st_r.target_match  <= 1'b1;
      st_r.trailer_match <= 1'b1;
    end else if (in_accept) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    if (in_accept) begin
      out_valid_nxt = res.valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res.valid) begin
      out_value_r   <= res.value;
      out_kind_r    <= res.kind;
      out_trailer_r <= res.is_trailer;
      out_last_r    <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_trailer_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule
